>>> rtl/ecsd_pkg.sv
// ----------------------------------------------------------------------------
// ecsd_pkg
// Shared types and constants of the charge start decider: command and
// register codes, fixed-point constants and the structs passed between stages.
// ----------------------------------------------------------------------------
`default_nettype none

package ecsd_pkg;

	// Command codes of an input transaction
	localparam logic CMD_DECIDE = 1'b0;
	localparam logic CMD_LOAD   = 1'b1;

	// Configuration register indexes
	localparam int CFG_INDEX_BITS = 2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_VOLTAGE = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_RATE    = 2'd1;

	// Register reset values
	localparam logic [15:0] MIN_VOLTAGE_RST = 16'd21600;
	localparam logic [15:0] MAX_RATE_RST    = 16'd3300;

	// Q2.14 unity and its negation
	localparam logic signed [15:0] L_ONE       = 16'sd16384;
	localparam logic signed [15:0] L_MINUS_ONE = -16'sd16384;
	localparam logic [14:0]        N_ONE       = 15'd16384;
	localparam logic [14:0]        P_ONE       = 15'd16384;

	// State of charge thresholds, 1/256 percent
	localparam logic [14:0] SOC_LOW  = 15'd5120;
	localparam logic [14:0] SOC_FULL = 15'd25600;
	localparam logic [14:0] SOC_STOP = 15'd25088;

	// floor(y / 5) = (y * 52429) >> 18 for y below 2^18
	localparam logic [15:0] RECIP_FIFTH = 16'd52429;
	localparam int          RECIP_SHIFT = 18;

	// Quotient bits of the voltage term division, one per divider stage
	localparam int QUOT_BITS = 15;

	typedef enum logic [1:0] {
		LSEL_DIV,
		LSEL_ONE,
		LSEL_MINUS_ONE
	} lsel_t;

	// Sideband carried alongside the divider
	typedef struct packed {
		logic        cmd;
		logic [6:0]  slot;
		logic [15:0] word;
		lsel_t       lsel;
		logic [14:0] nterm;
		logic        plugged;
		logic        busy;
		logic        stop;
		logic [15:0] draw;
	} meta_t;

	// Decision data carried through the table lookup
	typedef struct packed {
		logic               cmd;
		logic signed [15:0] lterm;
		logic [14:0]        nterm;
		logic [14:0]        p;
		logic               plugged;
		logic               busy;
		logic               stop;
		logic [15:0]        draw;
	} dec_t;

endpackage

`default_nettype wire

>>> rtl/ecsd_divider.sv
// ----------------------------------------------------------------------------
// ecsd_divider
// Pipelined restoring divider: q = floor(num * 2^14 / den) for num <= den,
// one quotient bit per stage, with a sideband struct kept in step.
// ----------------------------------------------------------------------------
`default_nettype none

module ecsd_divider (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [15:0]       num,
	input  wire logic [15:0]       den,
	input  wire ecsd_pkg::meta_t   in_meta,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [ecsd_pkg::QUOT_BITS-1:0] quo,
	output ecsd_pkg::meta_t        out_meta
);

	localparam int Steps = ecsd_pkg::QUOT_BITS;

	logic                 v_s    [Steps];
	logic                 adv    [Steps+1];
	logic [15:0]          rem_s  [Steps];
	logic [15:0]          den_s  [Steps];
	logic [Steps-1:0]     quo_s  [Steps];
	ecsd_pkg::meta_t      meta_s [Steps];

	assign adv[Steps] = out_ready;

	for (genvar k = 0; k < Steps; k++) begin : g_step
		logic [16:0]      part;
		logic [15:0]      den_in;
		logic [Steps-1:0] quo_in;
		ecsd_pkg::meta_t  meta_in;
		logic             v_in;
		logic             fit;

		if (k == 0) begin : g_first
			// The first step sees the numerator itself: quotient top bit set only when equal
			assign part    = {1'b0, num};
			assign den_in  = den;
			assign quo_in  = '0;
			assign meta_in = in_meta;
			assign v_in    = in_valid;
		end else begin : g_next
			assign part    = {rem_s[k-1], 1'b0};
			assign den_in  = den_s[k-1];
			assign quo_in  = quo_s[k-1];
			assign meta_in = meta_s[k-1];
			assign v_in    = v_s[k-1];
		end

		assign fit    = part >= {1'b0, den_in};
		assign adv[k] = !v_s[k] || adv[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (adv[k]) begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv[k]) begin
				rem_s[k]  <= fit ? 16'(part - {1'b0, den_in}) : part[15:0];
				den_s[k]  <= den_in;
				quo_s[k]  <= {quo_in[Steps-2:0], fit};
				meta_s[k] <= meta_in;
			end
		end
	end

	assign in_ready  = adv[0];
	assign out_valid = v_s[Steps-1];
	assign quo       = quo_s[Steps-1];
	assign out_meta  = meta_s[Steps-1];

endmodule

`default_nettype wire

>>> rtl/ecsd_interp.sv
// ----------------------------------------------------------------------------
// ecsd_interp
// Probability table memory and interpolation pipeline: table read, two
// weighted products, sum and scale down. Load transactions write the table.
// ----------------------------------------------------------------------------
`default_nettype none

module ecsd_interp #(
	parameter int TABLE_INDEX_BITS = 6
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire ecsd_pkg::dec_t in_dec,
	input  wire logic [6:0]     wr_slot,
	input  wire logic [15:0]    wr_word,
	output logic                out_valid,
	input  wire logic           out_ready,
	output ecsd_pkg::dec_t      out_dec,
	output logic [15:0]         out_pa
);

	localparam int Depth = (2 ** TABLE_INDEX_BITS) + 1;
	localparam int AW    = TABLE_INDEX_BITS + 1;
	localparam int Frac  = 14 - TABLE_INDEX_BITS;
	localparam int PW    = 17 + Frac;
	localparam logic [AW-1:0] LastIdx = AW'(2 ** TABLE_INDEX_BITS);
	localparam logic [Frac:0] FracOne = (Frac + 1)'(2 ** Frac);

	logic [15:0] mem [Depth];

	logic [AW-1:0]   idx;
	logic [AW-1:0]   idx_next;
	logic [Frac-1:0] frac;
	logic            slot_ok;
	logic [AW-1:0]   waddr;
	logic            adv_s1, adv_s2, adv_s3;

	logic            v_s1, v_s2, v_s3;
	ecsd_pkg::dec_t  dec_s1, dec_s2, dec_s3;
	logic [15:0]     t0_s1, t1_s1;
	logic [Frac-1:0] frac_s1;
	logic [Frac:0]   w0;
	logic [PW-1:0]   prod0_s2, prod1_s2;
	logic [15:0]     t0_s2;
	logic            frac_zero_s2;
	logic [PW-1:0]   acc;
	logic [15:0]     pa_s3;

	assign idx      = in_dec.p[14:Frac];
	assign frac     = in_dec.p[Frac-1:0];
	// The top entry has no right neighbour; its fraction is always zero there
	assign idx_next = (idx == LastIdx) ? idx : AW'(idx + AW'(1));
	assign slot_ok  = 32'(wr_slot) < 32'(Depth);
	assign waddr    = AW'(wr_slot);

	assign adv_s3 = !v_s3 || out_ready;
	assign adv_s2 = !v_s2 || adv_s3;
	assign adv_s1 = !v_s1 || adv_s2;
	assign in_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv_s1) begin
				v_s1 <= in_valid;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
			if (adv_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// Writes and reads happen at the same stage, so transactions meet the
	// table in arrival order and a read never overlaps a pending write.
	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			if (in_dec.cmd == ecsd_pkg::CMD_LOAD) begin
				if (slot_ok) begin
					mem[waddr] <= wr_word;
				end
			end else begin
				t0_s1 <= mem[idx];
				t1_s1 <= mem[idx_next];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			dec_s1  <= in_dec;
			frac_s1 <= frac;
		end
	end

	assign w0 = FracOne - {1'b0, frac_s1};

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			dec_s2       <= dec_s1;
			prod0_s2     <= PW'(t0_s1) * PW'(w0);
			prod1_s2     <= PW'(t1_s1) * PW'(frac_s1);
			t0_s2        <= t0_s1;
			frac_zero_s2 <= frac_s1 == '0;
		end
	end

	assign acc = prod0_s2 + prod1_s2;

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			dec_s3 <= dec_s2;
			// Take the left entry alone on an exact grid point
			pa_s3  <= frac_zero_s2 ? t0_s2 : acc[Frac+15:Frac];
		end
	end

	assign out_valid = v_s3;
	assign out_dec   = dec_s3;
	assign out_pa    = pa_s3;

endmodule

`default_nettype wire

>>> rtl/ev_charge_start_decider.sv
// ----------------------------------------------------------------------------
// ev_charge_start_decider
// Decides per vehicle whether charging starts, from line voltage, state of
// charge and a random draw, through a loaded probability table.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one transaction per cycle while
//   the output is not stalled. A decide transaction (command 0) describes
//   one vehicle; a load transaction (command 1) writes table_word into
//   table entry table_slot and returns a result with every field zero.
//   Slots beyond the table are dropped. Output channel (out_valid/out_ready)
//   gives one result per transaction, in order; throughput is one
//   transaction per cycle while the output is not stalled. The voltage
//   term comes from the 15-stage divider, one quotient bit per stage.
//   The configuration channel (cfg_valid/cfg_ready) is always ready; write
//   it only while no transaction is in flight.
//   When the receiver stalls, each stage holds its transaction and bubbles
//   close up, so input is refused only when every stage is full.
//   Reset loads the register defaults (min_voltage 21600, max_charge_rate
//   3300) and empties the pipeline. Table contents are undefined until
//   loaded; there is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module ev_charge_start_decider #(
	parameter int TABLE_INDEX_BITS = 6
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        command,
	input  wire logic [15:0] line_voltage,
	input  wire logic [15:0] valley_voltage,
	input  wire logic [14:0] charge_level,
	input  wire logic        connected,
	input  wire logic        charging_now,
	input  wire logic [15:0] random_draw,
	input  wire logic [6:0]  table_slot,
	input  wire logic [15:0] table_word,

	output logic               out_valid,
	input  wire logic          out_ready,
	output logic               charging,
	output logic               switched_on,
	output logic [15:0]        granted_rate,
	output logic signed [15:0] voltage_term,
	output logic [14:0]        charge_term,
	output logic [14:0]        base_probability,
	output logic [15:0]        applied_probability,

	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [ecsd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [15:0] cfg_data
);

	// Configuration
	logic [15:0] min_voltage_q;
	logic [15:0] max_rate_q;

	// Stage 1: captured input
	logic        v_s1;
	logic        cmd_s1;
	logic [15:0] line_s1, valley_s1;
	logic [14:0] level_s1;
	logic        plugged_s1, busy_s1;
	logic [15:0] draw_s1;
	logic [6:0]  slot_s1;
	logic [15:0] word_s1;

	// Stage 2: terms ready for division
	logic            v_s2;
	ecsd_pkg::meta_t meta_s2;
	logic [15:0]     num_s2, den_s2;

	logic            adv_s1, adv_s2;
	ecsd_pkg::lsel_t lsel;
	logic [16:0]     soc_gap;
	logic [32:0]     soc_prod;
	logic [14:0]     nterm;

	logic            div_in_ready;
	logic            div_valid;
	logic            div_ready;
	logic [ecsd_pkg::QUOT_BITS-1:0] div_quo;
	ecsd_pkg::meta_t div_meta;

	logic signed [15:0] lterm;
	logic [16:0]        psum;
	ecsd_pkg::dec_t     dec;

	logic           ip_valid;
	logic           ip_ready;
	ecsd_pkg::dec_t ip_dec;
	logic [15:0]    ip_pa;

	logic        out_valid_q;
	logic        charging_q, switched_on_q;
	logic [15:0] granted_rate_q;
	logic signed [15:0] voltage_term_q;
	logic [14:0] charge_term_q, base_probability_q;
	logic [15:0] applied_probability_q;
	logic        out_adv;
	logic        eligible;
	logic        draw_hit;

	// ---------------------------------------------------------------- config
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_voltage_q <= ecsd_pkg::MIN_VOLTAGE_RST;
			max_rate_q    <= ecsd_pkg::MAX_RATE_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				ecsd_pkg::CFG_MIN_VOLTAGE: min_voltage_q <= cfg_data;
				ecsd_pkg::CFG_MAX_RATE:    max_rate_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// --------------------------------------------------------------- stage 1
	assign adv_s2   = !v_s2 || div_in_ready;
	assign adv_s1   = !v_s1 || adv_s2;
	assign in_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				v_s1 <= in_valid;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			cmd_s1     <= command;
			line_s1    <= line_voltage;
			valley_s1  <= valley_voltage;
			level_s1   <= charge_level;
			plugged_s1 <= connected;
			busy_s1    <= charging_now;
			draw_s1    <= random_draw;
			slot_s1    <= table_slot;
			word_s1    <= table_word;
		end
	end

	// Voltage term: saturate above the valley, below min, or if valley <= min
	always_comb begin
		if (line_s1 > valley_s1) begin
			lsel = ecsd_pkg::LSEL_ONE;
		end else if (line_s1 < min_voltage_q) begin
			lsel = ecsd_pkg::LSEL_MINUS_ONE;
		end else if (valley_s1 <= min_voltage_q) begin
			lsel = ecsd_pkg::LSEL_ONE;
		end else begin
			lsel = ecsd_pkg::LSEL_DIV;
		end
	end

	// N = floor((full - level) * 4 / 5) between the low and full marks
	assign soc_gap  = {15'(ecsd_pkg::SOC_FULL - level_s1), 2'b00};
	assign soc_prod = 33'(soc_gap) * 33'(ecsd_pkg::RECIP_FIFTH);

	always_comb begin
		if (level_s1 < ecsd_pkg::SOC_LOW) begin
			nterm = ecsd_pkg::N_ONE;
		end else if (level_s1 > ecsd_pkg::SOC_FULL) begin
			nterm = '0;
		end else begin
			nterm = soc_prod[ecsd_pkg::RECIP_SHIFT+14:ecsd_pkg::RECIP_SHIFT];
		end
	end

	// --------------------------------------------------------------- stage 2
	always_ff @(posedge clk) begin
		if (adv_s2) begin
			meta_s2.cmd     <= cmd_s1;
			meta_s2.slot    <= slot_s1;
			meta_s2.word    <= word_s1;
			meta_s2.lsel    <= lsel;
			meta_s2.nterm   <= nterm;
			meta_s2.plugged <= plugged_s1;
			meta_s2.busy    <= busy_s1;
			meta_s2.stop    <= level_s1 > ecsd_pkg::SOC_STOP;
			meta_s2.draw    <= draw_s1;
			num_s2          <= line_s1 - min_voltage_q;
			den_s2          <= valley_s1 - min_voltage_q;
		end
	end

	ecsd_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.in_ready  (div_in_ready),
		.num       (num_s2),
		.den       (den_s2),
		.in_meta   (meta_s2),
		.out_valid (div_valid),
		.out_ready (div_ready),
		.quo       (div_quo),
		.out_meta  (div_meta)
	);

	// ------------------------------------------------------ combine the terms
	always_comb begin
		unique case (div_meta.lsel)
			ecsd_pkg::LSEL_ONE:       lterm = ecsd_pkg::L_ONE;
			ecsd_pkg::LSEL_MINUS_ONE: lterm = ecsd_pkg::L_MINUS_ONE;
			ecsd_pkg::LSEL_DIV:       lterm = signed'({1'b0, div_quo});
			default:                  lterm = '0;
		endcase
	end

	assign psum = {lterm[15], lterm} + {2'b00, div_meta.nterm};

	always_comb begin
		dec.cmd     = div_meta.cmd;
		dec.lterm   = lterm;
		dec.nterm   = div_meta.nterm;
		// Clamp a negative sum to zero, then halve
		dec.p       = psum[16] ? '0 : psum[15:1];
		dec.plugged = div_meta.plugged;
		dec.busy    = div_meta.busy;
		dec.stop    = div_meta.stop;
		dec.draw    = div_meta.draw;
	end

	ecsd_interp #(
		.TABLE_INDEX_BITS (TABLE_INDEX_BITS)
	) u_interp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (div_valid),
		.in_ready  (div_ready),
		.in_dec    (dec),
		.wr_slot   (div_meta.slot),
		.wr_word   (div_meta.word),
		.out_valid (ip_valid),
		.out_ready (ip_ready),
		.out_dec   (ip_dec),
		.out_pa    (ip_pa)
	);

	// ---------------------------------------------------------- output stage
	assign out_adv  = !out_valid_q || out_ready;
	assign ip_ready = out_adv;
	assign eligible = ip_dec.plugged && !ip_dec.stop;
	assign draw_hit = ip_dec.draw < ip_pa;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_adv) begin
			out_valid_q <= ip_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv && ip_valid) begin
			if (ip_dec.cmd == ecsd_pkg::CMD_LOAD) begin
				charging_q            <= 1'b0;
				switched_on_q         <= 1'b0;
				granted_rate_q        <= '0;
				voltage_term_q        <= '0;
				charge_term_q         <= '0;
				base_probability_q    <= '0;
				applied_probability_q <= '0;
			end else begin
				charging_q            <= eligible && (ip_dec.busy || draw_hit);
				switched_on_q         <= eligible && !ip_dec.busy && draw_hit;
				granted_rate_q        <= (eligible && (ip_dec.busy || draw_hit)) ?
				                         max_rate_q : '0;
				voltage_term_q        <= ip_dec.lterm;
				charge_term_q         <= ip_dec.nterm;
				base_probability_q    <= ip_dec.p;
				applied_probability_q <= ip_pa;
			end
		end
	end

	assign out_valid           = out_valid_q;
	assign charging            = charging_q;
	assign switched_on         = switched_on_q;
	assign granted_rate        = granted_rate_q;
	assign voltage_term        = voltage_term_q;
	assign charge_term         = charge_term_q;
	assign base_probability    = base_probability_q;
	assign applied_probability = applied_probability_q;

	// ------------------------------------------------------------ assertions
	a_start_implies_charge : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!switched_on || charging))
		else $error("switched_on without charging");

	a_rate_only_when_charging : assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !charging) |-> (granted_rate == '0))
		else $error("rate granted to a vehicle that does not charge");

	a_probability_in_range : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (base_probability <= ecsd_pkg::P_ONE))
		else $error("base probability above one");

	a_voltage_term_in_range : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (voltage_term <= ecsd_pkg::L_ONE && voltage_term >= ecsd_pkg::L_MINUS_ONE))
		else $error("voltage term outside -1..1");

	a_stall_from_output : assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input refused while the output is free");

endmodule

`default_nettype wire
